### rtl/depth_to_turbo_colormap_defines.svh
// assertion macros for the depth to turbo colormap block
`ifndef DEPTH_TO_TURBO_COLORMAP_DEFINES_SVH
`define DEPTH_TO_TURBO_COLORMAP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked property, off while reset is asserted
`define DTTC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// checked property, also during reset
`define DTTC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define DTTC_ASSERT(label, clk, rst_n, prop)
`define DTTC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/dttc_pkg.sv
// shared types, widths and polynomial coefficients for the turbo colormap
package dttc_pkg;

    localparam int DEPTH_W  = 32;
    localparam int T_W      = 17;
    localparam int ACC_W    = 33;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = ACC_W + T_W + 1;
    localparam int CLAMP_W  = 23;
    localparam int BYTE_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int NUM_COEF = 6;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam int ONE_Q16   = 65536;
    localparam int HALF_Q16  = 32768;
    localparam int ONE_Q22   = 4194304;
    localparam int HALF_Q22  = 2097152;

    // register indexes on the config port
    localparam logic [1:0] REG_DEPTH_LOW  = 2'd0;
    localparam logic [1:0] REG_DEPTH_HIGH = 2'd1;
    localparam logic [1:0] REG_SPAN_RECIP = 2'd2;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [T_W-1:0]           t_tval;
    typedef logic [BYTE_W-1:0]        t_byte;

    // red, green, blue; lowest degree first, 22 fraction bits
    localparam t_coef COEF [NUM_CH][NUM_COEF] = '{
        '{32'sd569257, 32'sd19358360, -32'sd178930362,
          32'sd554197927, -32'sd641486895, 32'sd248665098},
        '{32'sd383370, 32'sd9203093, 32'sd20312874,
          -32'sd59496342, 32'sd17940291, 32'sd11868060},
        '{32'sd447420, 32'sd53024165, -32'sd254099528,
          32'sd462894998, -32'sd377080970, 32'sd114706873}
    };

endpackage

### rtl/dttc_ifs.sv
// valid/ready channel interfaces for depth samples and colors
interface dttc_depth_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] depth_value;
    logic               depth_finite;

    modport source (output valid, output depth_value, output depth_finite, input ready);
    modport sink (input valid, input depth_value, input depth_finite, output ready);
endinterface

interface dttc_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/dttc_depth_to_t.sv
// three stage front end: window offset, reciprocal multiply, saturated t
module dttc_depth_to_t import dttc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [DEPTH_W-1:0] i_depth_value,
    input  logic                      i_depth_finite,
    input  logic signed [DEPTH_W-1:0] i_depth_low,
    input  logic signed [DEPTH_W-1:0] i_depth_high,
    input  logic [DEPTH_W-1:0]        i_span_recip,
    output t_tval                     o_t
);

    logic signed [DEPTH_W-1:0] n_depth;
    logic signed [DEPTH_W:0]   n_diff;
    logic signed [DEPTH_W:0]   r_diff;
    logic                      r_nonpos;
    logic [2*DEPTH_W-1:0]      r_prod;
    logic [DEPTH_W:0]          n_rem;
    t_tval                     n_t;
    t_tval                     r_t;

    always_comb begin
        n_depth = i_depth_finite ? i_depth_value : i_depth_high;
        n_diff  = {n_depth[DEPTH_W-1], n_depth} - {i_depth_low[DEPTH_W-1], i_depth_low};
    end

    // one minus the product, kept to 16 fraction bits; 1.0 for a non-positive offset, 0 once the product reaches 1.0
    always_comb begin
        n_rem = {1'b1, {DEPTH_W{1'b0}}} - {1'b0, r_prod[DEPTH_W-1:0]};
        if (r_nonpos) begin
            n_t = T_W'(ONE_Q16);
        end else if (r_prod[2*DEPTH_W-1:DEPTH_W] != '0) begin
            n_t = '0;
        end else begin
            n_t = n_rem[DEPTH_W:DEPTH_W-T_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff   <= n_diff;
            r_nonpos <= r_diff[DEPTH_W] || (r_diff == '0);
            r_prod   <= r_diff[DEPTH_W-1:0] * i_span_recip;
            r_t      <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

### rtl/dttc_horner_step.sv
// one horner step for all three channels: multiply stage, round and add stage
module dttc_horner_step import dttc_pkg::*; #(
    parameter int COEF_IDX = 4
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_tval i_t,
    input  t_acc  i_acc [NUM_CH],
    output t_tval o_t,
    output t_acc  o_acc [NUM_CH]
);

    logic signed [PROD_W-1:0] r_prod [NUM_CH];
    logic [PROD_W-1:0]        n_sum  [NUM_CH];
    t_acc                     n_acc  [NUM_CH];
    t_acc                     r_acc  [NUM_CH];
    t_tval                    r_t_mul;
    t_tval                    r_t_add;

    // round half up then drop 16 fraction bits
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_sum[c] = r_prod[c] + PROD_W'(HALF_Q16);
            n_acc[c] = n_sum[c][ACC_W+15:16] + ACC_W'(COEF[c][COEF_IDX]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_prod[c] <= i_acc[c] * $signed({1'b0, i_t});
                r_acc[c]  <= n_acc[c];
            end
            r_t_mul <= i_t;
            r_t_add <= r_t_mul;
        end
    end

    assign o_t   = r_t_add;
    assign o_acc = r_acc;

endmodule

### rtl/dttc_quantize.sv
// clamp each channel to [0,1] then scale by 255 with round half up
module dttc_quantize import dttc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_acc  i_acc  [NUM_CH],
    output t_byte o_byte [NUM_CH]
);

    logic [CLAMP_W-1:0]        n_clamp  [NUM_CH];
    logic [CLAMP_W-1:0]        r_clamp  [NUM_CH];
    logic [CLAMP_W+BYTE_W-1:0] n_scaled [NUM_CH];
    t_byte                     r_byte   [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (i_acc[c][ACC_W-1]) begin
                n_clamp[c] = '0;
            end else if (i_acc[c] > ACC_W'(ONE_Q22)) begin
                n_clamp[c] = CLAMP_W'(ONE_Q22);
            end else begin
                n_clamp[c] = i_acc[c][CLAMP_W-1:0];
            end
            // times 255 as times 256 minus one
            n_scaled[c] = {r_clamp[c], {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, r_clamp[c]}
                          + (CLAMP_W+BYTE_W)'(HALF_Q22);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_clamp[c] <= n_clamp[c];
                r_byte[c]  <= n_scaled[c][CLAMP_W+BYTE_W-2:CLAMP_W-1];
            end
        end
    end

    assign o_byte = r_byte;

endmodule

### rtl/depth_to_turbo_colormap.sv
// depth to turbo colormap: one depth sample in, one rgb color out
//
// i_depth carries a signed Q16.16 depth sample and a finite flag; a request
// is taken when valid and ready are both high. o_color returns the red, green
// and blue bytes of the turbo color for that sample, one result per request,
// in order. The window is set through the APB port: depth_low at 0x0,
// depth_high at 0x4, span_reciprocal at 0x8; write only while idle.
// Throughput is one request per cycle while the skid register is empty. A
// result passes through 16 register stages, the first loaded by the edge
// that takes its request: three to form t, two per horner step over five
// steps (multiplier, then round and add), one clamp stage, one scaling stage
// and the output register.
// When the receiver stalls, one more result parks in a skid register and the
// whole pipeline then holds; i_depth.ready comes straight from a flop.
// Reset empties the pipeline and the output side and loads the window
// registers with low 0.0, high 1.0 and reciprocal 1.0.
`include "depth_to_turbo_colormap_defines.svh"

module depth_to_turbo_colormap import dttc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    dttc_depth_if.sink        i_depth,
    dttc_color_if.source      o_color
);

    localparam int NUM_STEPS = NUM_COEF - 1;
    localparam int T_STAGES  = 3;
    localparam int NS        = T_STAGES + 2 * NUM_STEPS + 2;

    logic signed [DEPTH_W-1:0] r_depth_low;
    logic signed [DEPTH_W-1:0] r_depth_high;
    logic [DEPTH_W-1:0]        r_span_recip;
    logic                      w_cfg_wr;

    logic [NS-1:0] r_vld;
    logic          w_en;
    logic          w_push;
    logic          w_take;

    t_tval w_t   [NUM_STEPS+1];
    t_acc  w_acc [NUM_STEPS+1][NUM_CH];
    t_byte w_byte [NUM_CH];

    logic  r_out_vld;
    t_byte r_out  [NUM_CH];
    logic  r_skid_vld;
    t_byte r_skid [NUM_CH];

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_low  <= '0;
            r_depth_high <= DEPTH_W'(ONE_Q16);
            r_span_recip <= DEPTH_W'(ONE_Q16);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_DEPTH_LOW:  r_depth_low  <= pwdata;
                REG_DEPTH_HIGH: r_depth_high <= pwdata;
                REG_SPAN_RECIP: r_span_recip <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DEPTH_LOW:  prdata = r_depth_low;
            REG_DEPTH_HIGH: prdata = r_depth_high;
            REG_SPAN_RECIP: prdata = r_span_recip;
            default:        prdata = '0;
        endcase
    end

    // pipeline moves as a whole unless the skid register is holding a result
    assign w_en          = !r_skid_vld;
    assign i_depth.ready = w_en;
    assign w_push        = w_en && r_vld[NS-1];
    assign w_take        = r_out_vld && o_color.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_depth.valid};
        end
    end

    dttc_depth_to_t u_depth_to_t (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_depth_value  (i_depth.depth_value),
        .i_depth_finite (i_depth.depth_finite),
        .i_depth_low    (r_depth_low),
        .i_depth_high   (r_depth_high),
        .i_span_recip   (r_span_recip),
        .o_t            (w_t[0])
    );

    // horner starts from the top coefficient
    for (genvar c = 0; c < NUM_CH; c++) begin : g_init
        assign w_acc[0][c] = ACC_W'(COEF[c][NUM_COEF-1]);
    end

    for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
        dttc_horner_step #(
            .COEF_IDX (NUM_COEF - 2 - s)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_t   (w_t[s]),
            .i_acc (w_acc[s]),
            .o_t   (w_t[s+1]),
            .o_acc (w_acc[s+1])
        );
    end

    dttc_quantize u_quantize (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_acc  (w_acc[NUM_STEPS]),
        .o_byte (w_byte)
    );

    // output register plus one skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_vld <= w_push;
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || w_take) begin
            r_out <= w_byte;
        end else begin
            r_skid <= w_byte;
        end
    end

    assign o_color.valid = r_out_vld;
    assign o_color.red   = r_out[0];
    assign o_color.green = r_out[1];
    assign o_color.blue  = r_out[2];

    `DTTC_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_vld |-> r_out_vld)
    `DTTC_ASSERT(a_skid_only_on_stall, i_clk, i_rst_n, $rose(r_skid_vld) |-> $past(r_out_vld && !o_color.ready))
    `DTTC_ASSERT(a_stalled_result_kept, i_clk, i_rst_n, (r_out_vld && !o_color.ready && w_push) |=> (r_out_vld && r_skid_vld))
    `DTTC_ASSERT(a_t_in_range, i_clk, i_rst_n, r_vld[T_STAGES-1] |-> (w_t[0] <= T_W'(ONE_Q16)))
    `DTTC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!r_out_vld && !r_skid_vld && r_vld == '0))

endmodule

### tb/sv/tb.sv
// testbench for the depth to turbo colormap block: directed and random depth samples
module tb;
    import dttc_pkg::*;

    localparam int     PIPE_LATENCY = 32;
    localparam int     LIMIT_CYCLES = 400000;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_ITEMS = 140;
    localparam int     FULL_RATE_ITEMS = 125;
    localparam longint HALF_RANGE = 64'sd2147483648;
    localparam logic [31:0] DEPTH_MIN = 32'h8000_0000;
    localparam logic [31:0] DEPTH_MAX = 32'h7FFF_FFFF;
    localparam logic [1:0]  REG_UNUSED = 2'd3;

    // turbo polynomials, lowest degree first, 22 fraction bits
    localparam longint TURBO_COEF [3][6] = '{
        '{569257, 19358360, -178930362, 554197927, -641486895, 248665098},
        '{383370, 9203093, 20312874, -59496342, 17940291, 11868060},
        '{447420, 53024165, -254099528, 462894998, -377080970, 114706873}
    };

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
    } t_color;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dttc_depth_if depth_if ();
    dttc_color_if color_if ();

    depth_to_turbo_colormap u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_depth (depth_if),
        .o_color (color_if)
    );

    logic signed [31:0] win_low;
    logic signed [31:0] win_high;
    logic [31:0]        win_recip;
    t_color             color_q [$];
    int                 mismatch_count;
    int                 cycle_count;
    bit                 src_idle;
    bit                 sink_idle;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_color turbo_color(logic [31:0] value, logic finite);
        longint     sample;
        longint     diff;
        longint     t;
        longint     acc;
        bit [63:0]  prod;
        t_byte      chan [3];
        sample = finite ? longint'(signed'(value)) : longint'(win_high);
        diff = sample - longint'(win_low);
        if (diff <= 0) begin
            t = ONE_Q16;
        end else begin
            prod = 64'(diff) * {32'd0, win_recip};
            if (prod >= 64'h1_0000_0000) begin
                t = 0;
            end else begin
                t = longint'((64'h1_0000_0000 - prod) >> 16);
            end
        end
        for (int c = 0; c < 3; c++) begin
            acc = TURBO_COEF[c][5];
            // horner step, round half up on the 16 dropped bits
            for (int k = 4; k >= 0; k--) begin
                acc = ((acc * t + HALF_Q16) >>> 16) + TURBO_COEF[c][k];
            end
            if (acc < 0) begin
                acc = 0;
            end else if (acc > ONE_Q22) begin
                acc = ONE_Q22;
            end
            chan[c] = t_byte'((acc * 255 + HALF_Q22) >>> 22);
        end
        return '{red: chan[0], green: chan[1], blue: chan[2]};
    endfunction

    // mostly inside the window, some near its edges, some anywhere
    function automatic logic [31:0] pick_depth(longint lo, longint hi);
        longint    m;
        longint    v;
        bit [63:0] rnd;
        int        kind;
        kind = $urandom_range(0, 15);
        m = (hi - lo) / 8 + 2;
        rnd = {$urandom, $urandom};
        if (kind < 2) begin
            return $urandom;
        end
        if (kind < 4) begin
            v = (kind == 2 ? lo : hi) + longint'($urandom_range(0, 4)) - 2;
        end else begin
            v = lo - m + longint'(rnd % 64'(hi - lo + 2 * m + 1));
        end
        if (v < -HALF_RANGE) begin
            v = -HALF_RANGE;
        end else if (v >= HALF_RANGE) begin
            v = HALF_RANGE - 1;
        end
        return v[31:0];
    endfunction

    task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            case (idx)
                REG_DEPTH_LOW:  win_low = data;
                REG_DEPTH_HIGH: win_high = data;
                REG_SPAN_RECIP: win_recip = data;
                default: ;
            endcase
        end else if (prdata !== data) begin
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, idx, data, prdata);
            mismatch_count++;
        end
    endtask

    task automatic set_window(input logic [31:0] low, input logic [31:0] high,
                              input logic [31:0] recip);
        logic [31:0] vals [3];
        logic [1:0]  idxs [3];
        vals = '{low, high, recip};
        idxs = '{REG_DEPTH_LOW, REG_DEPTH_HIGH, REG_SPAN_RECIP};
        for (int i = 0; i < 3; i++) begin
            reg_access(1'b1, idxs[i], vals[i]);
            reg_access(1'b0, idxs[i], vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_depth(input logic [31:0] value, input logic finite);
        depth_if.valid        <= 1'b1;
        depth_if.depth_value  <= value;
        depth_if.depth_finite <= finite;
        do @(posedge i_clk); while (!depth_if.ready);
        color_q.push_back(turbo_color(value, finite));
        if (src_idle && $urandom_range(0, 5) == 0) begin
            depth_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // must be called in the step of the last request so valid drops in time
    task automatic drain_colors;
        depth_if.valid <= 1'b0;
        while (color_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic test_default_window;
        send_depth(32'd0, 1'b1);
        send_depth(32'd65536, 1'b1);
        send_depth(32'd32768, 1'b1);
        send_depth(32'd16384, 1'b1);
        send_depth(32'd49152, 1'b1);
        send_depth(32'd1, 1'b1);
        send_depth(32'd65535, 1'b1);
        send_depth(32'hFFFF_FFFF, 1'b1);
        send_depth(DEPTH_MIN, 1'b1);
        send_depth(DEPTH_MAX, 1'b1);
        send_depth(32'd0, 1'b0);
        send_depth(DEPTH_MAX, 1'b0);
        drain_colors();
    endtask

    task automatic test_zero_reciprocal;
        set_window(32'd0, 32'd65536, 32'd0);
        send_depth(DEPTH_MAX, 1'b1);
        send_depth(32'd12345, 1'b1);
        send_depth(32'd0, 1'b0);
        drain_colors();
    endtask

    task automatic test_extreme_windows;
        set_window(DEPTH_MIN, DEPTH_MAX, 32'd1);
        send_depth(DEPTH_MIN, 1'b1);
        send_depth(DEPTH_MAX, 1'b1);
        send_depth(32'd0, 1'b1);
        send_depth(32'd0, 1'b0);
        drain_colors();
        // full-scale reciprocal, product overflows well past 1.0 at the top of the window
        set_window(DEPTH_MIN, DEPTH_MAX, 32'hFFFF_FFFF);
        send_depth(DEPTH_MIN + 32'd1, 1'b1);
        send_depth(DEPTH_MAX, 1'b1);
        send_depth(DEPTH_MIN, 1'b1);
        drain_colors();
        set_window(DEPTH_MAX, DEPTH_MIN, 32'h8000_0000);
        send_depth(32'd0, 1'b0);
        send_depth(DEPTH_MAX, 1'b1);
        drain_colors();
    endtask

    task automatic test_unknown_register;
        reg_access(1'b1, REG_UNUSED, 32'hFFFF_FFFF);
        psel    <= 1'b0;
        penable <= 1'b0;
        send_depth(32'd0, 1'b0);
        send_depth(32'h4000_0000, 1'b1);
        drain_colors();
    endtask

    task automatic run_random_phase(input int n_items);
        longint      span;
        longint      lo;
        longint      hi;
        logic [31:0] low;
        logic [31:0] high;
        logic [31:0] recip;
        bit [63:0]   rnd;
        if ($urandom_range(0, 3) == 0) begin
            low   = $urandom;
            high  = $urandom;
            recip = $urandom >> $urandom_range(0, 31);
        end else begin
            // window whose reciprocal maps low..high onto 1..0
            span = longint'($urandom >> $urandom_range(0, 31));
            if (span == 0) begin
                span = 1;
            end
            rnd   = {$urandom, $urandom};
            lo    = longint'(rnd % (64'h1_0000_0000 - 64'(span))) - HALF_RANGE;
            hi    = lo + span;
            low   = lo[31:0];
            high  = hi[31:0];
            recip = (span == 1) ? 32'hFFFF_FFFF : 32'(64'h1_0000_0000 / 64'(span));
        end
        set_window(low, high, recip);
        lo = longint'(signed'(low));
        hi = longint'(signed'(high));
        if (hi < lo) begin
            span = lo;
            lo   = hi;
            hi   = span;
        end
        repeat (n_items) begin
            send_depth(pick_depth(lo, hi), $urandom_range(0, 15) != 0);
        end
        drain_colors();
    endtask

    task automatic test_random_windows;
        for (int i = 0; i < RANDOM_PHASES; i++) begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            run_random_phase(PHASE_ITEMS);
        end
    endtask

    task automatic test_full_rate;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        run_random_phase(FULL_RATE_ITEMS);
    endtask

    task automatic check_field(input string name, input t_byte want, input t_byte got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_colors
        t_color want;
        if (i_rst_n && color_if.valid && color_if.ready) begin
            if (color_q.size() == 0) begin
                $display("%0t: unexpected color expected none actual %0d %0d %0d",
                         $time, color_if.red, color_if.green, color_if.blue);
                mismatch_count++;
            end else begin
                want = color_q.pop_front();
                check_field("red", want.red, color_if.red);
                check_field("green", want.green, color_if.green);
                check_field("blue", want.blue, color_if.blue);
            end
        end
    end

    initial begin : color_sink
        color_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (sink_idle && $urandom_range(0, 5) == 0) begin
                color_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                color_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        src_idle       = 1'b1;
        sink_idle      = 1'b1;
        win_low        = 32'sd0;
        win_high       = 32'sd65536;
        win_recip      = 32'd65536;
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        depth_if.valid        <= 1'b0;
        depth_if.depth_value  <= '0;
        depth_if.depth_finite <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_window();
        test_zero_reciprocal();
        test_extreme_windows();
        test_unknown_register();
        test_random_windows();
        test_full_rate();

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### depth_to_turbo_colormap.f
+incdir+rtl
rtl/dttc_pkg.sv
rtl/dttc_ifs.sv
rtl/dttc_depth_to_t.sv
rtl/dttc_horner_step.sv
rtl/dttc_quantize.sv
rtl/depth_to_turbo_colormap.sv
tb/sv/tb.sv
